[sv/sctc_pkg.sv]
`timescale 1ns / 1ps

package sctc_pkg;

	// Default geometry
	localparam int NUM_SLOTS_DEF   = 64;
	localparam int SECTOR_BITS_DEF = 32;

	// Fixed widths of the result word
	localparam int KIND_W   = 2;
	localparam int SLOT_W   = 6;
	localparam int TARGET_W = 32;

	// Request operation codes
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_FLUSH = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Result kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_ACCESS     = 2'd0,
		KIND_WRITE_BACK = 2'd1,
		KIND_FILL       = 2'd2,
		KIND_FLUSH      = 2'd3
	} kind_t;

	// Controller to datapath commands
	typedef struct packed {
		logic  load_req;
		logic  scan_start;
		logic  scan_step;
		logic  rd_victim;
		logic  emit;
		kind_t emit_kind;
		logic  emit_last;
		logic  adv_ptr;
		logic  fill_wr;
		logic  set_dirty;
		logic  flush_start;
		logic  flush_rd;
		logic  flush_next;
		logic  clr_dirty;
		logic  flush_clear;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		op_t  in_op;
		logic op_write;
		logic scan_match;
		logic scan_end;
		logic scan_free;
		logic cur_dirty;
		logic last_dirty;
		logic no_dirty;
		logic out_free;
	} sts_t;

endpackage

[sv/sctc_if.sv]
`timescale 1ns / 1ps

// Request channel
interface sctc_req_if #(
	parameter int SECTOR_BITS = 32
);
	logic                   valid;
	logic                   ready;
	logic [1:0]             operation;
	logic [SECTOR_BITS-1:0] sector;

	modport source (output valid, output operation, output sector, input ready);
	modport sink (input valid, input operation, input sector, output ready);
endinterface

// Result channel
interface sctc_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [5:0]  slot;
	logic [31:0] target_sector;
	logic        hit;
	logic        last;

	modport source (output valid, output kind, output slot, output target_sector,
		output hit, output last, input ready);
	modport sink (input valid, input kind, input slot, input target_sector,
		input hit, input last, output ready);
endinterface

[sv/sctc_ram.sv]
`timescale 1ns / 1ps

module sctc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single write port, registered read that holds between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/sctc_datapath.sv]
`timescale 1ns / 1ps

module sctc_datapath import sctc_pkg::*; #(
	parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
	parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             in_operation,
	input  logic [SECTOR_BITS-1:0] in_sector,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [KIND_W-1:0]      out_kind,
	output logic [SLOT_W-1:0]      out_slot,
	output logic [TARGET_W-1:0]    out_target,
	output logic                   out_hit,
	output logic                   out_last
);

	localparam int SW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);
	localparam logic [SW:0]   SLOT_CNT  = (SW + 1)'(NUM_SLOTS);

	// Request registers
	op_t                    op_q;
	logic [SECTOR_BITS-1:0] sector_q;

	// Scan state
	logic [SW:0]            idx_q;
	logic                   chk_vld_s1;
	logic [SW-1:0]          chk_idx_s1;
	logic                   free_found_q;
	logic [SW-1:0]          free_slot_q;
	logic [SW-1:0]          slot_q;
	logic                   hit_q;

	// Policy state
	logic [SW-1:0]          ptr_q;
	logic [NUM_SLOTS-1:0]   valid_q;
	logic [NUM_SLOTS-1:0]   dirty_q;
	logic [CW-1:0]          dcnt_q;

	// Output register
	logic                   out_vld_q;
	logic [KIND_W-1:0]      out_kind_q;
	logic [SLOT_W-1:0]      out_slot_q;
	logic [TARGET_W-1:0]    out_target_q;
	logic                   out_hit_q;
	logic                   out_last_q;

	// Tag store
	logic                   ram_re;
	logic [SW-1:0]          ram_raddr;
	logic [SECTOR_BITS-1:0] tag_rdata;

	logic                   idx_in_range;
	logic                   cur_valid;
	logic                   chk_match;
	logic                   chk_free;
	logic                   chk_end;
	logic [SW-1:0]          idx_slot;

	assign idx_slot     = idx_q[SW-1:0];
	assign idx_in_range = idx_q < SLOT_CNT;

	// Compare the slot whose tag just came out of the RAM
	assign cur_valid = valid_q[chk_idx_s1];
	assign chk_match = chk_vld_s1 && cur_valid && (tag_rdata == sector_q);
	assign chk_free  = chk_vld_s1 && !cur_valid;
	assign chk_end   = chk_vld_s1 && (chk_idx_s1 == LAST_SLOT) && !chk_match;

	// Tag RAM read port: scan, victim or flush
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_slot;
		if (cmd.scan_step && idx_in_range) begin
			ram_re = 1'b1;
		end
		if (cmd.flush_rd) begin
			ram_re = 1'b1;
		end
		if (cmd.rd_victim) begin
			ram_re    = 1'b1;
			ram_raddr = slot_q;
		end
	end

	sctc_ram #(
		.WIDTH (SECTOR_BITS),
		.DEPTH (NUM_SLOTS)
	) u_tag_ram (
		.clk   (clk),
		.we    (cmd.fill_wr),
		.waddr (slot_q),
		.wdata (sector_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (tag_rdata)
	);

	// Request capture and slot selection
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			sector_q <= in_sector;
		end
		if (chk_free && !free_found_q) begin
			free_slot_q <= chk_idx_s1;
		end
		if (chk_match) begin
			slot_q <= chk_idx_s1;
		end else if (chk_end) begin
			slot_q <= free_found_q ? free_slot_q : (chk_free ? chk_idx_s1 : ptr_q);
		end else if (cmd.flush_rd) begin
			slot_q <= idx_slot;
		end
		if (cmd.scan_step || cmd.scan_start || cmd.flush_rd) begin
			chk_idx_s1 <= idx_slot;
		end
	end

	// Scan control; a match stops further compares so slot_q holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= OP_READ;
			idx_q        <= '0;
			chk_vld_s1   <= 1'b0;
			free_found_q <= 1'b0;
			hit_q        <= 1'b0;
		end else begin
			chk_vld_s1 <= cmd.scan_step && idx_in_range && !chk_match;
			if (cmd.load_req) begin
				op_q <= op_t'(in_operation);
			end
			if (cmd.scan_start || cmd.flush_start) begin
				idx_q <= '0;
			end else if ((cmd.scan_step && idx_in_range) || cmd.flush_next) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.scan_start) begin
				free_found_q <= 1'b0;
				hit_q        <= 1'b0;
			end else begin
				if (chk_free) begin
					free_found_q <= 1'b1;
				end
				if (chk_match) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// Valid and dirty marks, dirty count, victim pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			dcnt_q  <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd.flush_clear) begin
				valid_q <= '0;
				dirty_q <= '0;
				dcnt_q  <= '0;
				ptr_q   <= '0;
			end else begin
				if (cmd.adv_ptr) begin
					ptr_q <= (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;
				end
				if (cmd.fill_wr) begin
					valid_q[slot_q] <= 1'b1;
					dirty_q[slot_q] <= 1'b0;
					if (dirty_q[slot_q]) begin
						dcnt_q <= dcnt_q - 1'b1;
					end
				end else if (cmd.set_dirty) begin
					dirty_q[slot_q] <= 1'b1;
					if (!dirty_q[slot_q]) begin
						dcnt_q <= dcnt_q + 1'b1;
					end
				end else if (cmd.clr_dirty) begin
					dirty_q[slot_q] <= 1'b0;
					dcnt_q          <= dcnt_q - 1'b1;
				end
			end
		end
	end

	// Output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q <= cmd.emit_kind;
			out_last_q <= cmd.emit_last;
			case (cmd.emit_kind)
				KIND_ACCESS: begin
					out_slot_q   <= SLOT_W'(slot_q);
					out_target_q <= '0;
					out_hit_q    <= hit_q;
				end
				KIND_WRITE_BACK: begin
					out_slot_q   <= SLOT_W'(slot_q);
					out_target_q <= TARGET_W'(tag_rdata);
					out_hit_q    <= 1'b0;
				end
				KIND_FILL: begin
					out_slot_q   <= SLOT_W'(slot_q);
					out_target_q <= TARGET_W'(sector_q);
					out_hit_q    <= 1'b0;
				end
				default: begin
					out_slot_q   <= '0;
					out_target_q <= '0;
					out_hit_q    <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid  = out_vld_q;
	assign out_kind   = out_kind_q;
	assign out_slot   = out_slot_q;
	assign out_target = out_target_q;
	assign out_hit    = out_hit_q;
	assign out_last   = out_last_q;

	// Status to controller
	always_comb begin
		sts            = '0;
		sts.in_op      = op_t'(in_operation);
		sts.op_write   = (op_q == OP_WRITE);
		sts.scan_match = chk_match;
		sts.scan_end   = chk_end;
		sts.scan_free  = free_found_q || chk_free;
		sts.cur_dirty  = dirty_q[idx_slot];
		sts.last_dirty = (dcnt_q == CW'(1));
		sts.no_dirty   = (dcnt_q == '0);
		sts.out_free   = !out_vld_q || out_ready;
	end

endmodule

[sv/sctc_ctrl.sv]
`timescale 1ns / 1ps

module sctc_ctrl import sctc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_VREAD,
		ST_VWB,
		ST_FILL,
		ST_ACC,
		ST_FLUSH,
		ST_FWB,
		ST_FDONE
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load_req = 1'b1;
					unique case (sts.in_op) inside
						OP_READ, OP_WRITE: begin
							cmd.scan_start = 1'b1;
							state_nxt      = ST_LOOKUP;
						end
						OP_FLUSH: begin
							cmd.flush_start = 1'b1;
							state_nxt       = sts.no_dirty ? ST_FDONE : ST_FLUSH;
						end
						default: begin
							state_nxt = ST_IDLE;
						end
					endcase
				end
			end
			// One slot per cycle through the tag RAM
			ST_LOOKUP: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_match) begin
					state_nxt = ST_ACC;
				end else if (sts.scan_end) begin
					state_nxt = sts.scan_free ? ST_FILL : ST_VREAD;
				end
			end
			ST_VREAD: begin
				cmd.rd_victim = 1'b1;
				state_nxt     = ST_VWB;
			end
			ST_VWB: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_WRITE_BACK;
					cmd.adv_ptr   = 1'b1;
					state_nxt     = ST_FILL;
				end
			end
			ST_FILL: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_FILL;
					cmd.fill_wr   = 1'b1;
					state_nxt     = ST_ACC;
				end
			end
			ST_ACC: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_ACCESS;
					cmd.emit_last = 1'b1;
					cmd.set_dirty = sts.op_write;
					state_nxt     = ST_IDLE;
				end
			end
			// Walk the dirty marks, reading the tag of each dirty slot
			ST_FLUSH: begin
				if (sts.cur_dirty) begin
					cmd.flush_rd = 1'b1;
					state_nxt    = ST_FWB;
				end else begin
					cmd.flush_next = 1'b1;
				end
			end
			ST_FWB: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_WRITE_BACK;
					cmd.emit_last = sts.last_dirty;
					cmd.clr_dirty = 1'b1;
					if (sts.last_dirty) begin
						cmd.flush_clear = 1'b1;
						state_nxt       = ST_IDLE;
					end else begin
						cmd.flush_next = 1'b1;
						state_nxt      = ST_FLUSH;
					end
				end
			end
			ST_FDONE: begin
				if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_kind   = KIND_FLUSH;
					cmd.emit_last   = 1'b1;
					cmd.flush_clear = 1'b1;
					state_nxt       = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[sv/sector_cache_tag_controller_top.sv]
`timescale 1ns / 1ps

// Read/write: the tag scan reads one tag RAM slot per cycle and stops at a hit or after the last slot,
// then the result words follow; a full miss first reads the victim tag for a write-back word.
// Flush: skips clean slots, emits a write-back word per dirty slot, or one flush word if none is dirty.
// One request at a time; the next is taken once the last word sits in the output register.
// Reset clears valid and dirty marks and the victim pointer at once; tag RAM is not cleared.
module sector_cache_tag_controller_top import sctc_pkg::*; #(
	parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
	parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sctc_req_if.sink   req,
	sctc_rsp_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	sctc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sctc_datapath #(
		.NUM_SLOTS   (NUM_SLOTS),
		.SECTOR_BITS (SECTOR_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_operation (req.operation),
		.in_sector    (req.sector),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.out_kind     (rsp.kind),
		.out_slot     (rsp.slot),
		.out_target   (rsp.target_sector),
		.out_hit      (rsp.hit),
		.out_last     (rsp.last)
	);

endmodule
